// File: design/afk4_pkg.sv
// Package for the 4-joint arm forward kinematics unit.
// Holds the CORDIC arctangent table, turn constants and the stage record type.
// No dependencies.
`timescale 1ns / 1ps

package afk4_pkg;

    localparam int UNITS_PER_TURN  = 23040;
    localparam int HALF_TURN_UNITS = 11520;
    localparam logic signed [19:0] GAIN_Q16 = 20'sd39797;

    localparam int NUM_REGS = 7;
    localparam logic [2:0] REG_BASE_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_UPPER_ARM    = 3'd1;
    localparam logic [2:0] REG_FOREARM      = 3'd2;
    localparam logic [2:0] REG_WRIST        = 3'd3;
    localparam logic [2:0] REG_LATERAL      = 3'd4;
    localparam logic [2:0] REG_TOOL         = 3'd5;
    localparam logic [2:0] REG_JOINT_OFFSET = 3'd6;

    // CORDIC working word: Q2.16 values grow a little, 20 bits is ample.
    typedef logic signed [19:0] cval_t;
    typedef logic signed [32:0] phase_t;

    // One rotator lane: x, y, residual angle, final negate flag.
    typedef struct packed {
        cval_t  x;
        cval_t  y;
        phase_t z;
        logic   flip;
    } lane_t;

    // Everything one item carries down the cell row.
    typedef struct packed {
        logic   valid;
        logic   ok;
        lane_t  l1;
        lane_t  l2;
        lane_t  l23;
        lane_t  l234;
    } cell_data_t;

    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10680862;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10431;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            24: t = 32'd41;
            25: t = 32'd20;
            26: t = 32'd10;
            27: t = 32'd5;
            28: t = 32'd3;
            29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// File: design/arm_forward_kinematics_4dof_unit.sv
// Top level of the 4-joint arm forward kinematics unit.
// Instantiates afk4_phase, a row of afk4_cell and afk4_pose; uses afk4_pkg.
//
// Usage:
//   s_axis channel: one transfer carries four signed joint angles in 1/64 deg.
//   m_axis channel: one transfer per input carries X, Y, Z (1/256 mm, saturated)
//   and pose_valid. Invalid poses (any corrected angle beyond +-180 deg)
//   give zero position with pose_valid low.
//   cfg channel: cfg_index picks a register (0..6 in list order), cfg_data is
//   the value; indexes beyond six are dropped. Write only while idle.
// Pipeline: 2 front-end stages + min(CORDIC_ITERATIONS, 32) cells + 5 back-end
//   stages (the last one is the output register).
// Throughput: one item per cycle while the row advances; each cell is one
//   micro-rotation stage of the row, the whole row advances together.
// Stall: when m_axis_tready is low and the output holds data, the whole row
//   holds; s_axis_tready drops in the same way. While the output slot is
//   empty the row advances even under stall.
// Reset: aresetn (synchronous, active low) empties the row and clears all
//   configuration registers to zero.
`timescale 1ns / 1ps

module arm_forward_kinematics_4dof_unit #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_BITS        = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint1_angle[15:0], joint2_angle[31:16], joint3_angle[47:32], joint4_angle[63:48]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_position[31:0], y_position[63:32], z_position[95:64]
    output logic [95:0]  m_axis_tdata,
    // pose_valid[0]
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int ITER = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

    // configuration registers
    logic [23:0] base_height_reg, upper_arm_reg, forearm_reg, wrist_reg;
    logic [23:0] lateral_reg, tool_reg;
    logic [63:0] joint_offsets_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_height_reg   <= '0;
            upper_arm_reg     <= '0;
            forearm_reg       <= '0;
            wrist_reg         <= '0;
            lateral_reg       <= '0;
            tool_reg          <= '0;
            joint_offsets_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                afk4_pkg::REG_BASE_HEIGHT:  base_height_reg   <= cfg_data[23:0];
                afk4_pkg::REG_UPPER_ARM:    upper_arm_reg     <= cfg_data[23:0];
                afk4_pkg::REG_FOREARM:      forearm_reg       <= cfg_data[23:0];
                afk4_pkg::REG_WRIST:        wrist_reg         <= cfg_data[23:0];
                afk4_pkg::REG_LATERAL:      lateral_reg       <= cfg_data[23:0];
                afk4_pkg::REG_TOOL:         tool_reg          <= cfg_data[23:0];
                afk4_pkg::REG_JOINT_OFFSET: joint_offsets_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole row unless the output holds an untaken result
    logic advance;
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    afk4_pkg::cell_data_t row [ITER + 1];

    afk4_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_axis_tvalid),
        .angles   (s_axis_tdata),
        .offsets  (joint_offsets_reg),
        .d_out    (row[0])
    );

    for (genvar i = 0; i < ITER; i++) begin : g_cell
        afk4_cell #(.STEP(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .d_in    (row[i]),
            .d_out   (row[i+1])
        );
    end

    logic [96:0] pose_data;

    afk4_pose u_pose (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .d_in      (row[ITER]),
        .l0        (base_height_reg),
        .l1        (upper_arm_reg),
        .l2        (forearm_reg),
        .l3        (wrist_reg),
        .l4        (lateral_reg),
        .l5        (tool_reg),
        .out_valid (m_axis_tvalid),
        .out_data  (pose_data)
    );

    assign m_axis_tdata = pose_data[95:0];
    assign m_axis_tuser = pose_data[96];

endmodule

// File: design/afk4_cell.sv
// One CORDIC micro-rotation cell, applied to all four lanes of an item.
// Depends on afk4_pkg.
`timescale 1ns / 1ps

module afk4_cell #(
    parameter int STEP = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  afk4_pkg::cell_data_t  d_in,
    output afk4_pkg::cell_data_t  d_out
);

    localparam afk4_pkg::phase_t ATAN =
        afk4_pkg::phase_t'({1'b0, afk4_pkg::atan_turn32(STEP)});

    afk4_pkg::cell_data_t data_reg, data_next;

    function automatic afk4_pkg::lane_t rotate(input afk4_pkg::lane_t a);
        afk4_pkg::lane_t r;
        afk4_pkg::cval_t dx, dy;
        dx = a.y >>> STEP;
        dy = a.x >>> STEP;
        r = a;
        if (!a.z[32]) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ATAN;
        end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ATAN;
        end
        return r;
    endfunction

    always_comb begin
        data_next       = d_in;
        data_next.l1    = rotate(d_in.l1);
        data_next.l2    = rotate(d_in.l2);
        data_next.l23   = rotate(d_in.l23);
        data_next.l234  = rotate(d_in.l234);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else if (advance) begin
            data_reg.valid <= data_next.valid;
        end
        if (advance) begin
            data_reg.ok   <= data_next.ok;
            data_reg.l1   <= data_next.l1;
            data_reg.l2   <= data_next.l2;
            data_reg.l23  <= data_next.l23;
            data_reg.l234 <= data_next.l234;
        end
    end

    assign d_out = data_reg;

endmodule

// File: design/afk4_phase.sv
// Front end: offset subtraction, range check, angle sums and phase mapping.
// Two registered stages; the phase scaling uses two constant multiplies per lane.
// Depends on afk4_pkg.
`timescale 1ns / 1ps

module afk4_phase #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [63:0]           angles,
    input  logic [63:0]           offsets,
    output afk4_pkg::cell_data_t  d_out
);

    localparam int AB = (ANGLE_BITS > 32) ? 32 : ANGLE_BITS;

    // stage A: corrected angles and reduced sums
    logic        a_valid_reg;
    logic        a_ok_reg;
    logic [14:0] a_r_reg [4];

    logic signed [16:0] corr [4];
    logic signed [19:0] sums [4];
    logic [14:0]        red  [4];
    logic               ok_c;

    // wrap a sum in (-2 turns, 3 turns) into [0, 1 turn); one compare/add chain
    function automatic logic [14:0] reduce(input logic signed [19:0] s);
        logic signed [19:0] v;
        v = s;
        if (v < 0) v = v + 20'sd23040;
        if (v < 0) v = v + 20'sd23040;
        if (v >= 20'sd23040) v = v - 20'sd23040;
        if (v >= 20'sd23040) v = v - 20'sd23040;
        return v[14:0];
    endfunction

    always_comb begin
        ok_c = 1'b1;
        for (int k = 0; k < 4; k++) begin
            corr[k] = 17'(signed'(angles[16*k +: 16])) - 17'(signed'(offsets[16*k +: 16]));
            if (corr[k] > 17'sd11520 || corr[k] < -17'sd11520) ok_c = 1'b0;
        end
        // inside the valid range every sum stays within +-2 turns
        sums[0] = 20'(corr[0]);
        sums[1] = 20'(corr[1]);
        sums[2] = 20'(corr[1]) + 20'(corr[2]);
        sums[3] = 20'(corr[1]) + 20'(corr[2]) + 20'(corr[3]);
        for (int k = 0; k < 4; k++) red[k] = reduce(sums[k]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) a_valid_reg <= 1'b0;
        else if (advance) a_valid_reg <= in_valid;
        if (advance) begin
            a_ok_reg <= ok_c;
            for (int k = 0; k < 4; k++) a_r_reg[k] <= red[k];
        end
    end

    // stage B: phase = floor((r*2^AB + 11520)/23040) mod 2^AB.
    // With 23040 = 45 * 2^9 and r = 45*a + b this is a * 2^(AB-9) plus the
    // rounded fraction floor((b*2^(AB-8) + 45)/90) from a 45-entry table.
    localparam logic [14:0] RECIP45 = 15'd23302;   // ceil(2^20 / 45)

    function automatic logic [45*32-1:0] frac_table();
        logic [45*32-1:0] t;
        t = '0;
        for (int i = 0; i < 45; i++)
            t[32*i +: 32] = 32'(((64'(i) << (AB - 8)) + 64'd45) / 64'd90);
        return t;
    endfunction

    localparam logic [45*32-1:0] FRAC_TAB = frac_table();

    function automatic logic [31:0] to_phase(input logic [14:0] r);
        logic [29:0] prod;
        logic [8:0]  a;
        logic [5:0]  b;
        logic [32:0] q;
        prod = 30'(r) * 30'(RECIP45);
        a    = prod[28:20];
        b    = 6'(r - 15'(a) * 15'd45);
        q    = (33'(a) << (AB - 9)) + 33'(FRAC_TAB[{b, 5'd0} +: 32]);
        return 32'(q[31:0] << (32 - AB));
    endfunction

    function automatic afk4_pkg::lane_t seed(input logic [14:0] r);
        afk4_pkg::lane_t l;
        afk4_pkg::phase_t z;
        z = afk4_pkg::phase_t'(signed'(to_phase(r)));
        l.flip = 1'b0;
        if (z > 33'sd1073741824) begin
            z = z - 33'sd2147483648;
            l.flip = 1'b1;
        end else if (z < -33'sd1073741824) begin
            z = z + 33'sd2147483648;
            l.flip = 1'b1;
        end
        l.x = afk4_pkg::GAIN_Q16;
        l.y = '0;
        l.z = z;
        return l;
    endfunction

    afk4_pkg::cell_data_t b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) b_reg.valid <= 1'b0;
        else if (advance) b_reg.valid <= a_valid_reg;
        if (advance) begin
            b_reg.ok   <= a_ok_reg;
            b_reg.l1   <= seed(a_r_reg[0]);
            b_reg.l2   <= seed(a_r_reg[1]);
            b_reg.l23  <= seed(a_r_reg[2]);
            b_reg.l234 <= seed(a_r_reg[3]);
        end
    end

    assign d_out = b_reg;

endmodule

// File: design/afk4_pose.sv
// Back end: products of link lengths and sin/cos, rounding and saturation.
// Pipelined, one multiply level between registers. Depends on afk4_pkg.
`timescale 1ns / 1ps

module afk4_pose (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  afk4_pkg::cell_data_t  d_in,
    input  logic [23:0]           l0,
    input  logic [23:0]           l1,
    input  logic [23:0]           l2,
    input  logic [23:0]           l3,
    input  logic [23:0]           l4,
    input  logic [23:0]           l5,
    output logic                  out_valid,
    output logic [96:0]           out_data
);

    typedef logic signed [19:0] trig_t;

    // stage 1: apply flip
    logic  p1_valid_reg, p1_ok_reg;
    trig_t c1_reg, s1_reg, c2_reg, s2_reg, c23_reg, s23_reg, c234_reg, s234_reg;

    function automatic trig_t fx(input afk4_pkg::lane_t l);
        return l.flip ? -l.x : l.x;
    endfunction
    function automatic trig_t fy(input afk4_pkg::lane_t l);
        return l.flip ? -l.y : l.y;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) p1_valid_reg <= 1'b0;
        else if (advance) p1_valid_reg <= d_in.valid;
        if (advance) begin
            p1_ok_reg <= d_in.ok;
            c1_reg <= fx(d_in.l1);   s1_reg <= fy(d_in.l1);
            c2_reg <= fx(d_in.l2);   s2_reg <= fy(d_in.l2);
            c23_reg <= fx(d_in.l23); s23_reg <= fy(d_in.l23);
            c234_reg <= fx(d_in.l234); s234_reg <= fy(d_in.l234);
        end
    end

    // stage 2: ten 25x20 products
    logic signed [24:0] ul1, ul2, ul3, sl4, sl5;
    assign ul1 = 25'(l1);
    assign ul2 = 25'(l2);
    assign ul3 = 25'(l3);
    assign sl4 = 25'(signed'(l4));
    assign sl5 = 25'(signed'(l5));

    logic p2_valid_reg, p2_ok_reg;
    logic signed [44:0] m_l1c2_reg, m_l2c23_reg, m_l3c234_reg, m_l5s234_reg;
    logic signed [44:0] m_l5c234_reg, m_l1s2_reg, m_l2s23_reg, m_l3s234_reg;
    logic signed [44:0] m_l4s1_reg, m_l4c1_reg;
    trig_t c1b_reg, s1b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) p2_valid_reg <= 1'b0;
        else if (advance) p2_valid_reg <= p1_valid_reg;
        if (advance) begin
            p2_ok_reg    <= p1_ok_reg;
            m_l1c2_reg   <= 45'(ul1 * c2_reg);
            m_l2c23_reg  <= 45'(ul2 * c23_reg);
            m_l3c234_reg <= 45'(ul3 * c234_reg);
            m_l5s234_reg <= 45'(sl5 * s234_reg);
            m_l5c234_reg <= 45'(sl5 * c234_reg);
            m_l1s2_reg   <= 45'(ul1 * s2_reg);
            m_l2s23_reg  <= 45'(ul2 * s23_reg);
            m_l3s234_reg <= 45'(ul3 * s234_reg);
            m_l4s1_reg   <= 45'(sl4 * s1_reg);
            m_l4c1_reg   <= 45'(sl4 * c1_reg);
            c1b_reg <= c1_reg;
            s1b_reg <= s1_reg;
        end
    end

    // stage 3: sums R and Z
    logic p3_valid_reg, p3_ok_reg;
    logic signed [47:0] r_reg, zs_reg, l4s1_reg, l4c1_reg;
    trig_t c1c_reg, s1c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) p3_valid_reg <= 1'b0;
        else if (advance) p3_valid_reg <= p2_valid_reg;
        if (advance) begin
            p3_ok_reg <= p2_ok_reg;
            r_reg  <= 48'(m_l1c2_reg) + 48'(m_l2c23_reg) + 48'(m_l3c234_reg)
                    - 48'(m_l5s234_reg);
            zs_reg <= 48'(m_l5c234_reg) + 48'(m_l1s2_reg) + 48'(m_l2s23_reg)
                    + 48'(m_l3s234_reg);
            l4s1_reg <= 48'(m_l4s1_reg);
            l4c1_reg <= 48'(m_l4c1_reg);
            c1c_reg <= c1b_reg;
            s1c_reg <= s1b_reg;
        end
    end

    // stage 4: R times c1/s1, split in two partial products each (R low 24 / high 24)
    logic p4_valid_reg, p4_ok_reg;
    logic signed [44:0] cr_lo_reg, cr_hi_reg, sr_lo_reg, sr_hi_reg;
    logic signed [47:0] l4s1b_reg, l4c1b_reg, zsb_reg;
    logic signed [24:0] r_lo;
    logic signed [23:0] r_hi;
    assign r_lo = 25'({1'b0, r_reg[23:0]});
    assign r_hi = r_reg[47:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) p4_valid_reg <= 1'b0;
        else if (advance) p4_valid_reg <= p3_valid_reg;
        if (advance) begin
            p4_ok_reg <= p3_ok_reg;
            cr_lo_reg <= 45'(r_lo * c1c_reg);
            cr_hi_reg <= 45'(r_hi * c1c_reg);
            sr_lo_reg <= 45'(r_lo * s1c_reg);
            sr_hi_reg <= 45'(r_hi * s1c_reg);
            l4s1b_reg <= l4s1_reg;
            l4c1b_reg <= l4c1_reg;
            zsb_reg   <= zs_reg;
        end
    end

    // stage 5: combine, round, saturate
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'h7FFFFFFF;
        if (v < -72'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    logic signed [71:0] xs, ys, xq, yq, zq;
    always_comb begin
        xs = (72'(l4s1b_reg) <<< 16) + 72'(cr_lo_reg) + (72'(cr_hi_reg) <<< 24);
        ys = 72'(sr_lo_reg) + (72'(sr_hi_reg) <<< 24) - (72'(l4c1b_reg) <<< 16);
        xq = (xs + 72'sd2147483648) >>> 32;
        yq = (ys + 72'sd2147483648) >>> 32;
        // keep the whole sum signed so the shift stays arithmetic
        zq = signed'(72'(l0)) + ((72'(zsb_reg) + 72'sd32768) >>> 16);
    end

    logic        o_valid_reg;
    logic [96:0] o_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) o_valid_reg <= 1'b0;
        else if (advance) o_valid_reg <= p4_valid_reg;
        if (advance) begin
            if (p4_ok_reg) o_data_reg <= {1'b1, sat32(zq), sat32(yq), sat32(xq)};
            else           o_data_reg <= '0;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule
